FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the maze search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define GMR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmr assertion failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define GMR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmr assertion failed");

`endif

FILE: rtl/gmr_pkg.sv
// Package with the shared types and constants of the maze search block.
`timescale 1ns / 1ps
`default_nettype none

package gmr_pkg;

  // Default maze side limit
  localparam int MAX_SIDE_DEF = 16;

  // Cell classification codes
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_WALL  = 3'd1;
  localparam kind_t KIND_START = 3'd2;
  localparam kind_t KIND_END   = 3'd3;
  localparam kind_t KIND_BLANK = 3'd4;

  // Configuration port layout
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_MAZE_WIDTH  = 1'b0;
  localparam logic REG_MAZE_HEIGHT = 1'b1;

  // Side registers
  localparam int SIDE_REG_W = 5;
  localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 5'd16;

endpackage

`default_nettype wire

FILE: rtl/gmr_if.sv
// Valid/ready channel interfaces for maze cells in and the solved flag out.
`timescale 1ns / 1ps
`default_nettype none

interface gmr_in_if;
  import gmr_pkg::*;
  logic  valid;
  logic  ready;
  kind_t cell_kind;
  logic  last_cell;
  modport source (output valid, cell_kind, last_cell, input ready);
  modport sink   (input valid, cell_kind, last_cell, output ready);
endinterface

interface gmr_out_if;
  logic valid;
  logic ready;
  logic solved;
  modport source (output valid, solved, input ready);
  modport sink   (input valid, solved, output ready);
endinterface

`default_nettype wire

FILE: rtl/gmr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gmr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/grid_maze_reachability.sv
// Top level: maze cell loader and depth-first reachability search.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          cell_kind[2:0], last_cell
//   out_ch    out  valid/ready          solved
//   cfg_*     in   APB write, pready=1  maze_width @0x0, maze_height @0x4
//
// One cell loads per cycle while in_ch is ready; a maze_width write stalls in_ch while a
// bit-serial divider remaps the load row and column. A last cell starts a clearing pass
// over the visited map, a seed step, then pop, fetch and check per popped cell, a read and
// an evaluate per in-bounds neighbor, a read per out-of-bounds one (one read port per RAM),
// a pop on an empty stack, and a done step loading the output register once free. in_ch is
// not ready from the last cell until then. Reset (rst_n low, synchronous) clears control.
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_reachability #(
  parameter int MAX_SIDE = gmr_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gmr_in_if.sink                          in_ch,
  gmr_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gmr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [gmr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [gmr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  import gmr_pkg::*;

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int ROW_W  = $clog2(MAX_SIDE + 1);
  localparam int LP_W   = $clog2(CELLS + 1);
  localparam int STK_W  = $clog2(CELLS + 1);
  localparam int DCNT_W = $clog2(LP_W);
  localparam int AREA_W = 2 * SIDE_REG_W;

  // Neighbor visit codes, in push order
  localparam logic [1:0] NB_NORTH = 2'd0;
  localparam logic [1:0] NB_EAST  = 2'd1;
  localparam logic [1:0] NB_SOUTH = 2'd2;
  localparam logic [1:0] NB_WEST  = 2'd3;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIV   = 10'b00_0000_0010,
    S_CLEAR = 10'b00_0000_0100,
    S_SEED  = 10'b00_0000_1000,
    S_POP   = 10'b00_0001_0000,
    S_FETCH = 10'b00_0010_0000,
    S_CHECK = 10'b00_0100_0000,
    S_NREAD = 10'b00_1000_0000,
    S_NEVAL = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  // Clamp a side register to 1..MAX_SIDE
  function automatic logic [SIDE_REG_W-1:0] side_of(input logic [SIDE_REG_W-1:0] v);
    logic [SIDE_REG_W-1:0] s;
    s = v;
    if (v == '0) begin
      s = SIDE_REG_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      s = SIDE_REG_W'(MAX_SIDE);
    end
    return s;
  endfunction

  // Cell address from row and column
  function automatic logic [CELL_W-1:0] cell_idx(input logic [SIDE_W-1:0] r,
                                                 input logic [SIDE_W-1:0] c);
    return CELL_W'(32'(r) * MAX_SIDE + 32'(c));
  endfunction

  // Registers
  state_t                state_r, state_nxt;
  logic [SIDE_REG_W-1:0] width_reg_r, width_reg_nxt;
  logic [SIDE_REG_W-1:0] height_reg_r, height_reg_nxt;
  logic [LP_W-1:0]       lp_r, lp_nxt;
  logic [ROW_W-1:0]      ld_row_r, ld_row_nxt;
  logic [SIDE_W-1:0]     ld_col_r, ld_col_nxt;
  logic [SIDE_W-1:0]     start_row_r, start_row_nxt;
  logic [SIDE_W-1:0]     start_col_r, start_col_nxt;
  logic                  div_pending_r, div_pending_nxt;
  logic [DCNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic [LP_W-1:0]       div_num_r, div_num_nxt;
  logic [SIDE_REG_W-1:0] div_rem_r, div_rem_nxt;
  logic [LP_W-1:0]       div_quo_r, div_quo_nxt;
  logic [CELL_W-1:0]     clr_r, clr_nxt;
  logic [STK_W-1:0]      sp_r, sp_nxt;
  logic [1:0]            nb_r, nb_nxt;
  logic [SIDE_W-1:0]     cur_row_r, cur_row_nxt;
  logic [SIDE_W-1:0]     cur_col_r, cur_col_nxt;
  logic [SIDE_W-1:0]     nb_row_r, nb_row_nxt;
  logic [SIDE_W-1:0]     nb_col_r, nb_col_nxt;
  logic                  found_r, found_nxt;
  logic                  solved_r, solved_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Combinational
  logic [SIDE_REG_W-1:0] w_side, h_side;
  logic [AREA_W-1:0]     area;
  logic                  cfg_wr, wr_width, wr_height;
  logic                  in_xfer, ld_store;
  logic [SIDE_REG_W:0]   rem_sh;
  logic                  div_ge;
  logic [SIDE_REG_W-1:0] rem_new;
  logic [LP_W-1:0]       quo_new;
  logic                  nb_sel_row, nb_inc, nb_ok;
  logic [SIDE_W-1:0]     nb_op;
  logic [SIDE_REG_W-1:0] nb_lim;
  logic [SIDE_W:0]       nb_step;
  logic [SIDE_W-1:0]     nr, nc;
  logic                  enter;

  // RAM ports
  logic                  cell_we;
  logic [CELL_W-1:0]     cell_waddr, cell_raddr;
  kind_t                 cell_rdata;
  logic                  vis_we, vis_wdata;
  logic [CELL_W-1:0]     vis_waddr, vis_raddr;
  logic                  vis_rdata;
  logic                  stk_we;
  logic [CELL_W-1:0]     stk_waddr, stk_raddr;
  logic [2*SIDE_W-1:0]   stk_wdata, stk_rdata;

  // Configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign wr_width   = cfg_wr && (cfg_paddr[REG_SEL_BIT] == REG_MAZE_WIDTH);
  assign wr_height  = cfg_wr && (cfg_paddr[REG_SEL_BIT] == REG_MAZE_HEIGHT);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[REG_SEL_BIT] == REG_MAZE_HEIGHT)
                      ? CFG_DATA_W'(height_reg_r) : CFG_DATA_W'(width_reg_r);

  // Effective maze size
  assign w_side = side_of(width_reg_r);
  assign h_side = side_of(height_reg_r);
  assign area   = {{SIDE_REG_W{1'b0}}, w_side} * {{SIDE_REG_W{1'b0}}, h_side};

  // Channel handshakes
  assign in_ch.ready   = (state_r == S_IDLE) && !div_pending_r;
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign ld_store      = in_xfer && (32'(lp_r) < 32'(area));
  assign out_ch.valid  = out_valid_r;
  assign out_ch.solved = solved_r;

  // Divider step: load position over width, one quotient bit per cycle
  assign rem_sh  = {div_rem_r, div_num_r[LP_W-1]};
  assign div_ge  = rem_sh >= {1'b0, w_side};
  assign rem_new = div_ge ? SIDE_REG_W'(rem_sh - {1'b0, w_side})
                          : SIDE_REG_W'(rem_sh);
  assign quo_new = {div_quo_r[LP_W-2:0], div_ge};

  // Shared neighbor unit: one increment/decrement and bound check
  assign nb_sel_row = (nb_r == NB_NORTH) || (nb_r == NB_SOUTH);
  assign nb_inc     = (nb_r == NB_EAST) || (nb_r == NB_SOUTH);
  assign nb_op      = nb_sel_row ? cur_row_r : cur_col_r;
  assign nb_lim     = nb_sel_row ? h_side : w_side;
  assign nb_step    = nb_inc ? ({1'b0, nb_op} + 1'b1) : ({1'b0, nb_op} - 1'b1);
  assign nb_ok      = nb_inc ? (32'(nb_step) < 32'(nb_lim)) : (nb_op != '0);
  assign nr         = nb_sel_row ? nb_step[SIDE_W-1:0] : cur_row_r;
  assign nc         = nb_sel_row ? cur_col_r : nb_step[SIDE_W-1:0];

  // Neighbor may be entered
  assign enter = (cell_rdata != KIND_WALL) && (cell_rdata != KIND_BLANK) && !vis_rdata;

  // RAM address and write control
  always_comb begin
    cell_we    = ld_store;
    cell_waddr = cell_idx(ld_row_r[SIDE_W-1:0], ld_col_r);
    cell_raddr = (state_r == S_FETCH)
                 ? cell_idx(stk_rdata[2*SIDE_W-1:SIDE_W], stk_rdata[SIDE_W-1:0])
                 : cell_idx(nr, nc);
    vis_raddr  = cell_idx(nr, nc);
    vis_we     = 1'b0;
    vis_wdata  = 1'b0;
    vis_waddr  = clr_r;
    stk_we     = 1'b0;
    stk_waddr  = sp_r[CELL_W-1:0];
    stk_wdata  = {nb_row_r, nb_col_r};
    stk_raddr  = CELL_W'(sp_r - 1'b1);
    case (state_r)
      S_CLEAR: begin
        vis_we = 1'b1;
      end
      S_SEED: begin
        vis_we    = 1'b1;
        vis_wdata = 1'b1;
        vis_waddr = cell_idx(start_row_r, start_col_r);
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {start_row_r, start_col_r};
      end
      S_NEVAL: begin
        vis_we    = enter;
        vis_wdata = 1'b1;
        vis_waddr = cell_idx(nb_row_r, nb_col_r);
        stk_we    = enter && (32'(sp_r) < CELLS);
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    width_reg_nxt   = wr_width ? cfg_pwdata[SIDE_REG_W-1:0] : width_reg_r;
    height_reg_nxt  = wr_height ? cfg_pwdata[SIDE_REG_W-1:0] : height_reg_r;
    lp_nxt          = lp_r;
    ld_row_nxt      = ld_row_r;
    ld_col_nxt      = ld_col_r;
    start_row_nxt   = start_row_r;
    start_col_nxt   = start_col_r;
    div_pending_nxt = div_pending_r;
    div_cnt_nxt     = div_cnt_r;
    div_num_nxt     = div_num_r;
    div_rem_nxt     = div_rem_r;
    div_quo_nxt     = div_quo_r;
    clr_nxt         = clr_r;
    sp_nxt          = sp_r;
    nb_nxt          = nb_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    nb_row_nxt      = nb_row_r;
    nb_col_nxt      = nb_col_r;
    found_nxt       = found_r;
    solved_nxt      = solved_r;
    out_valid_nxt   = out_valid_r;

    // Result transfer frees the output register
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (div_pending_r) begin
          div_pending_nxt = 1'b0;
          div_cnt_nxt     = '0;
          div_num_nxt     = lp_r;
          div_rem_nxt     = '0;
          div_quo_nxt     = '0;
          state_nxt       = S_DIV;
        end else if (in_xfer) begin
          // Store the cell and advance the raster position
          if (ld_store) begin
            lp_nxt = lp_r + 1'b1;
            if (32'(ld_col_r) + 1 == 32'(w_side)) begin
              ld_col_nxt = '0;
              ld_row_nxt = ld_row_r + 1'b1;
            end else begin
              ld_col_nxt = ld_col_r + 1'b1;
            end
            if (in_ch.cell_kind == KIND_START) begin
              start_row_nxt = ld_row_r[SIDE_W-1:0];
              start_col_nxt = ld_col_r;
            end
          end
          if (in_ch.last_cell) begin
            lp_nxt     = '0;
            ld_row_nxt = '0;
            ld_col_nxt = '0;
            clr_nxt    = '0;
            state_nxt  = S_CLEAR;
          end
        end
      end
      S_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        div_num_nxt = {div_num_r[LP_W-2:0], 1'b0};
        div_rem_nxt = rem_new;
        div_quo_nxt = quo_new;
        if (div_cnt_r == DCNT_W'(LP_W - 1)) begin
          ld_row_nxt = ROW_W'(quo_new);
          ld_col_nxt = SIDE_W'(rem_new);
          state_nxt  = S_IDLE;
        end
      end
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        sp_nxt        = STK_W'(1);
        start_row_nxt = '0;
        start_col_nxt = '0;
        state_nxt     = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          sp_nxt    = sp_r - 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cur_row_nxt = stk_rdata[2*SIDE_W-1:SIDE_W];
        cur_col_nxt = stk_rdata[SIDE_W-1:0];
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (cell_rdata == KIND_END) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          nb_nxt    = NB_NORTH;
          state_nxt = S_NREAD;
        end
      end
      S_NREAD: begin
        if (nb_ok) begin
          nb_row_nxt = nr;
          nb_col_nxt = nc;
          state_nxt  = S_NEVAL;
        end else if (nb_r == NB_WEST) begin
          state_nxt = S_POP;
        end else begin
          nb_nxt = nb_r + 1'b1;
        end
      end
      S_NEVAL: begin
        if (enter && (32'(sp_r) < CELLS)) begin
          sp_nxt = sp_r + 1'b1;
        end
        if (nb_r == NB_WEST) begin
          state_nxt = S_POP;
        end else begin
          nb_nxt    = nb_r + 1'b1;
          state_nxt = S_NREAD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          solved_nxt    = found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new width reruns the divider once the block is idle
    if (wr_width) begin
      div_pending_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      width_reg_r   <= SIDE_RESET;
      height_reg_r  <= SIDE_RESET;
      lp_r          <= '0;
      ld_row_r      <= '0;
      ld_col_r      <= '0;
      start_row_r   <= '0;
      start_col_r   <= '0;
      div_pending_r <= 1'b0;
      sp_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      width_reg_r   <= width_reg_nxt;
      height_reg_r  <= height_reg_nxt;
      lp_r          <= lp_nxt;
      ld_row_r      <= ld_row_nxt;
      ld_col_r      <= ld_col_nxt;
      start_row_r   <= start_row_nxt;
      start_col_r   <= start_col_nxt;
      div_pending_r <= div_pending_nxt;
      sp_r          <= sp_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    div_cnt_r <= div_cnt_nxt;
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    clr_r     <= clr_nxt;
    nb_r      <= nb_nxt;
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    nb_row_r  <= nb_row_nxt;
    nb_col_r  <= nb_col_nxt;
    found_r   <= found_nxt;
    solved_r  <= solved_nxt;
  end

  // Cell kinds, raster addressed
  gmr_ram #(
    .WIDTH ($bits(kind_t)),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (in_ch.cell_kind),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // Visited map, swept clear before each search
  gmr_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  // Search stack of row/column pairs
  gmr_ram #(
    .WIDTH (2 * SIDE_W),
    .DEPTH (CELLS)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/gmr_checker.sv
// Port-level assertion checker for the maze search block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gmr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [gmr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input logic [gmr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input logic [gmr_pkg::CFG_DATA_W-1:0]  cfg_prdata
);

  import gmr_pkg::*;

  logic wr_width, wr_height;

  // Register write decode
  assign wr_width  = cfg_psel && cfg_penable && cfg_pwrite
                     && (cfg_paddr[REG_SEL_BIT] == REG_MAZE_WIDTH);
  assign wr_height = cfg_psel && cfg_penable && cfg_pwrite
                     && (cfg_paddr[REG_SEL_BIT] == REG_MAZE_HEIGHT);

  // A pending result holds until transferred
  `GMR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // The last cell starts a search, so input stalls right after it
  `GMR_ASSERT_NXT(a_last_busy, in_valid && in_ready && in_last, !in_ready)

  // A width write stalls input while the load position is remapped
  `GMR_ASSERT_NXT(a_width_remap, wr_width, !in_ready)

  // A result only appears as a search completes, never mid-load
  `GMR_ASSERT_IMP(a_result_after_search, $rose(out_valid), $past(!in_ready))

  // Height reads back what was just written
  `GMR_ASSERT_IMP(a_height_readback,
    wr_height ##1 (cfg_paddr[REG_SEL_BIT] == REG_MAZE_HEIGHT),
    cfg_prdata[SIDE_REG_W-1:0] == $past(cfg_pwdata[SIDE_REG_W-1:0]))

endmodule

bind grid_maze_reachability gmr_checker u_gmr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_cell),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

`default_nettype wire

FILE: tb/tb_grid_maze_reachability.sv
// Self-checking testbench for the grid maze reachability search block.
`timescale 1ns / 1ps

module tb_grid_maze_reachability;
  import gmr_pkg::*;

  localparam int SIDE          = MAX_SIDE_DEF;
  localparam int CELLS         = SIDE * SIDE;
  localparam int ITEM_TARGET   = 1650;
  localparam int CALM_AFTER    = 1400;
  localparam int HOLD_CYCLES   = 10000;
  localparam int HOLD_AT_MAZE  = 12;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES  = 300;
  localparam int REPORT_LIMIT  = 10;

  // Cell codes the package leaves unnamed
  localparam kind_t KIND_OPEN     = 3'd0;
  localparam kind_t KIND_SPARE_LO = 3'd5;
  localparam kind_t KIND_SPARE_HI = 3'd7;

  // Tracks the block's maze state and the solved flags still owed
  class maze_scoreboard;
    kind_t           cells[CELLS];
    bit              seen[CELLS];
    int              trail[$];
    logic [4:0]      width_reg;
    logic [4:0]      height_reg;
    int unsigned     fill;
    int unsigned     start_idx;
    bit              solved_q[$];
    int unsigned     faults;

    function new();
      foreach (cells[i]) cells[i] = KIND_OPEN;
      width_reg  = SIDE_RESET;
      height_reg = SIDE_RESET;
      fill       = 0;
      start_idx  = 0;
      faults     = 0;
    endfunction

    // 0 behaves as 1, anything above the limit as the limit
    function int unsigned side_len(logic [4:0] r);
      if (r == 0) return 1;
      if (r > SIDE) return SIDE;
      return r;
    endfunction

    function void write_reg(logic sel, logic [4:0] value);
      if (sel == REG_MAZE_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function void report_fault(string msg);
      faults++;
      if (faults <= REPORT_LIMIT) $display("%0t %s", $time, msg);
    endfunction

    function void step_into(int nb);
      if (cells[nb] != KIND_WALL && cells[nb] != KIND_BLANK && !seen[nb]) begin
        seen[nb] = 1'b1;
        trail.insert(trail.size(), nb);
      end
    endfunction

    // Stack walk; neighbors pushed N, E, S, W so they come off W, S, E, N
    function bit end_reachable(int unsigned w, int unsigned h);
      int cur;
      int row;
      int col;
      foreach (seen[i]) seen[i] = 1'b0;
      trail.delete();
      seen[start_idx] = 1'b1;
      trail.insert(trail.size(), start_idx);
      while (trail.size() != 0) begin
        cur = trail.pop_back();
        if (cells[cur] == KIND_END) return 1'b1;
        row = cur / SIDE;
        col = cur % SIDE;
        if (row > 0) step_into(cur - SIDE);
        if (col + 1 < w) step_into(cur + 1);
        if (row + 1 < h) step_into(cur + SIDE);
        if (col > 0) step_into(cur - 1);
      end
      return 1'b0;
    endfunction

    // One accepted cell transfer; the last one runs the search
    function void note_cell(kind_t kind, logic last);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      w = side_len(width_reg);
      h = side_len(height_reg);
      if (fill < w * h) begin
        idx = (fill / w) * SIDE + fill % w;
        cells[idx] = kind;
        if (kind == KIND_START) start_idx = idx;
        fill++;
      end
      if (last) begin
        solved_q.insert(solved_q.size(), end_reachable(w, h));
        fill      = 0;
        start_idx = 0;
      end
    endfunction

    function void check_flag(logic got);
      bit want;
      if (solved_q.size() == 0) begin
        report_fault($sformatf("solved flag %b with no maze pending", got));
        return;
      end
      want = solved_q.pop_front();
      if (got !== want)
        report_fault($sformatf("solved mismatch: expected %0d, got %b", want, got));
    endfunction

    function void drain_check();
      if (solved_q.size() != 0)
        report_fault($sformatf("%0d solved flags never arrived", solved_q.size()));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gmr_in_if  in_ch ();
  gmr_out_if out_ch ();

  maze_scoreboard sb = new();

  // Cells written since reset, so a short load never exposes stale-unknown cells
  bit          cell_written[CELLS];
  int unsigned cells_sent;
  bit          calm;
  bit          hold_off_req;

  grid_maze_reachability u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  // Monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_cell(in_ch.cell_kind, in_ch.last_cell);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_flag(out_ch.solved);
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : flag_receiver
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        gap = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // One cell transfer, with an optional idle burst ahead of it
  task automatic send_cell(input kind_t kind, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cell_kind <= kind;
    in_ch.last_cell <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_maze(input kind_t plan[$]);
    int unsigned w;
    int unsigned area;
    w    = sb.side_len(sb.width_reg);
    area = w * sb.side_len(sb.height_reg);
    foreach (plan[p]) begin
      if (p < area) begin
        cell_written[(p / w) * SIDE + p % w] = 1'b1;
        cells_sent++;
      end
      send_cell(plan[p], p == plan.size() - 1);
    end
  endtask

  // Drop valid and wait for every owed flag, then let the block settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.solved_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write; upper data bits carry junk half the time
  task automatic write_side(input logic sel, input logic [4:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    addr = '0;
    addr[REG_SEL_BIT] = sel;
    data = $urandom;
    if ($urandom_range(0, 1) == 0) data = '0;
    data[SIDE_REG_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(sel, value);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_side();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 5'd0;
    if (roll == 1) return 5'd1;
    if (roll == 2) return 5'd16;
    if (roll == 3) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(2, 7));
  endfunction

  // Mostly full mazes with a start and an end; some long, short or pure noise
  task automatic random_maze();
    kind_t       plan[$];
    int unsigned w;
    int unsigned area;
    int unsigned n;
    int unsigned shape;
    int unsigned density;
    int unsigned roll;
    w       = sb.side_len(sb.width_reg);
    area    = w * sb.side_len(sb.height_reg);
    shape   = $urandom_range(0, 9);
    density = $urandom_range(0, 45);
    n       = area;
    if (shape == 7) n = area + $urandom_range(1, 4);
    if (shape == 8 && area > 1) begin
      n = $urandom_range(1, area - 1);
      // fall back to a full load if any untouched cell would be exposed
      for (int p = n; p < area; p++)
        if (!cell_written[(p / w) * SIDE + p % w]) n = area;
    end
    for (int p = 0; p < n; p++) begin
      roll = $urandom_range(0, 99);
      if (shape == 9) plan.insert(plan.size(), kind_t'($urandom));
      else if (roll < density) plan.insert(plan.size(), KIND_WALL);
      else if (roll < density + 3) plan.insert(plan.size(), KIND_BLANK);
      else if (roll < density + 6)
        plan.insert(plan.size(), kind_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)));
      else plan.insert(plan.size(), KIND_OPEN);
    end
    if (shape != 9) begin
      if ($urandom_range(0, 7) != 0) plan[$urandom_range(0, n - 1)] = KIND_END;
      if ($urandom_range(0, 3) == 0) plan[$urandom_range(0, n - 1)] = KIND_END;
      if ($urandom_range(0, 7) != 0) plan[$urandom_range(0, n - 1)] = KIND_START;
      if ($urandom_range(0, 7) == 0) plan[$urandom_range(0, n - 1)] = KIND_START;
    end
    send_maze(plan);
  endtask

  initial begin : stimulus
    kind_t       singles[6];
    kind_t       row_plan[$];
    int unsigned maze_count;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cell_kind = KIND_OPEN;
    in_ch.last_cell = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    cells_sent      = 0;
    calm            = 1'b0;
    hold_off_req    = 1'b0;
    foreach (cell_written[i]) cell_written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-cell mazes (zero sides act as one): the package kinds, an open cell and a spare code at the start cell
    write_side(REG_MAZE_WIDTH, 5'd0);
    write_side(REG_MAZE_HEIGHT, 5'd0);
    singles = '{KIND_END, KIND_WALL, KIND_BLANK, KIND_START, KIND_OPEN, KIND_SPARE_HI};
    cell_written[0] = 1'b1;
    foreach (singles[i]) begin
      send_cell(singles[i], 1'b1);
      cells_sent++;
    end

    // Oversized width clamps to a full row; walk west to the end, extra cells dropped
    quiesce();
    write_side(REG_MAZE_WIDTH, 5'd31);
    row_plan.insert(row_plan.size(), KIND_END);
    repeat (SIDE - 2) row_plan.insert(row_plan.size(), KIND_OPEN);
    row_plan.insert(row_plan.size(), KIND_START);
    row_plan.insert(row_plan.size(), KIND_WALL);
    row_plan.insert(row_plan.size(), KIND_SPARE_LO);
    send_maze(row_plan);

    // Random mazes, new sides every few mazes
    maze_count = 0;
    while (cells_sent < ITEM_TARGET) begin
      if (maze_count % 5 == 0) begin
        quiesce();
        write_side(REG_MAZE_WIDTH, pick_side());
        write_side(REG_MAZE_HEIGHT, pick_side());
      end
      if (maze_count == HOLD_AT_MAZE) hold_off_req = 1'b1;
      if (cells_sent > CALM_AFTER) calm = 1'b1;
      random_maze();
      maze_count++;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.solved_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.drain_check();
    if (sb.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
